[sv/nsfp_pkg.sv]
// ----------------------------------------------------------------------------
// Nearest-square factor pair package
// Shared widths, sequencer states and the control bundle for the arithmetic
// units of the factor pair search.
// ----------------------------------------------------------------------------
package nsfp_pkg;

   localparam int NSFP_NUMBER_WIDTH = 32;
   localparam int NSFP_PORT_W       = 32;
   localparam int NSFP_SMALL_W      = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROOT,
      ST_LOAD,
      ST_DIVIDE,
      ST_CHECK,
      ST_EMIT
   } nsfp_state_type;

   typedef struct packed {
      logic load;
      logic step;
   } nsfp_ctl_type;

endpackage

[sv/nsfp_sqrt.sv]
// ----------------------------------------------------------------------------
// Integer square root unit
// Digit-by-digit restoring square root, one result bit per step.
// ----------------------------------------------------------------------------
module nsfp_sqrt
   import nsfp_pkg::*;
#(
   parameter int IN_W   = NSFP_NUMBER_WIDTH,
   parameter int ROOT_W = (NSFP_NUMBER_WIDTH + 1) / 2
) (
   input  logic              clock,
   input  nsfp_ctl_type      ctl,
   input  logic [IN_W-1:0]   radicand,
   output logic [ROOT_W-1:0] root
);

   localparam int SQ_W = 2 * ROOT_W;

   logic [SQ_W-1:0]   rad_ff, rad_in;
   logic [ROOT_W:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ROOT_W+2:0] shifted;
   logic [ROOT_W+2:0] diff;
   logic              take;

   always_comb begin
      shifted = {rem_ff, rad_ff[SQ_W-1 -: 2]};
      diff    = shifted - (ROOT_W+3)'({root_ff, 2'b01});
      take    = ~diff[ROOT_W+2];
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (ctl.load) begin
         rad_in  = SQ_W'(radicand);
         rem_in  = '0;
         root_in = '0;
      end else if (ctl.step) begin
         rad_in  = SQ_W'({rad_ff, 2'b00});
         rem_in  = take ? diff[ROOT_W:0] : shifted[ROOT_W:0];
         root_in = ROOT_W'({root_ff, take});
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;

endmodule

[sv/nsfp_div.sv]
// ----------------------------------------------------------------------------
// Trial divider unit
// Restoring divider, one quotient bit per step, with a zero remainder flag.
// ----------------------------------------------------------------------------
module nsfp_div
   import nsfp_pkg::*;
#(
   parameter int DIVIDEND_W = NSFP_NUMBER_WIDTH,
   parameter int DIVISOR_W  = (NSFP_NUMBER_WIDTH + 1) / 2
) (
   input  logic                  clock,
   input  nsfp_ctl_type          ctl,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic                  rem_zero
);

   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W+1:0]  diff;
   logic                  take;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff    = (DIVISOR_W+2)'(shifted) - (DIVISOR_W+2)'(divisor);
      take    = ~diff[DIVISOR_W+1];
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (ctl.load) begin
         rem_in = '0;
         quo_in = dividend;
      end else if (ctl.step) begin
         rem_in = take ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_in = DIVIDEND_W'({quo_ff, take});
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign rem_zero = (rem_ff == '0);

endmodule

[sv/nearest_square_factor_pair.sv]
// ----------------------------------------------------------------------------
// Nearest-square factor pair
// Splits a number into the factor pair with the smallest difference.
// ----------------------------------------------------------------------------
// One request is worked at a time and the block is not ready while it runs.
// A nonzero number of W = min(NUMBER_WIDTH, 32) significant bits first goes
// through the square root unit, then each candidate divisor, tried downward
// from the square root, is tried in the shared restoring divider until one
// leaves no remainder; zero skips the search and is reported as no solution.
// The result sits in an output register, so a new request is taken while it
// waits.
// ----------------------------------------------------------------------------
module nearest_square_factor_pair
   import nsfp_pkg::*;
#(
   parameter int NUMBER_WIDTH = NSFP_NUMBER_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [NSFP_PORT_W-1:0]  req_number,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [NSFP_PORT_W-1:0]  rsp_larger_factor,
   output logic [NSFP_SMALL_W-1:0] rsp_smaller_factor,
   output logic                    rsp_no_solution
);

   localparam int EFF_W  = (NUMBER_WIDTH < NSFP_PORT_W) ? NUMBER_WIDTH : NSFP_PORT_W;
   localparam int ROOT_W = (EFF_W + 1) / 2;
   localparam int CNT_W  = $clog2(EFF_W + 1);

   nsfp_state_type    state_ff, state_in;
   logic [EFF_W-1:0]  num_ff, num_in;
   logic [ROOT_W-1:0] cand_ff, cand_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              zero_ff, zero_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [NSFP_PORT_W-1:0]  rsp_large_ff, rsp_large_in;
   logic [NSFP_SMALL_W-1:0] rsp_small_ff, rsp_small_in;
   logic                    rsp_nosol_ff, rsp_nosol_in;

   nsfp_ctl_type      sqrt_ctl;
   nsfp_ctl_type      div_ctl;
   logic [EFF_W-1:0]  masked;
   logic [ROOT_W-1:0] root;
   logic [EFF_W-1:0]  quotient;
   logic              rem_zero;
   logic              slot_free;

   nsfp_sqrt #(
      .IN_W   (EFF_W),
      .ROOT_W (ROOT_W)
   ) u_sqrt (
      .clock    (clock),
      .ctl      (sqrt_ctl),
      .radicand (masked),
      .root     (root)
   );

   nsfp_div #(
      .DIVIDEND_W (EFF_W),
      .DIVISOR_W  (ROOT_W)
   ) u_div (
      .clock    (clock),
      .ctl      (div_ctl),
      .dividend (num_ff),
      .divisor  (cand_ff),
      .quotient (quotient),
      .rem_zero (rem_zero)
   );

   assign masked    = req_number[EFF_W-1:0];
   assign slot_free = ~rsp_valid_ff | rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      num_in        = num_ff;
      cand_in       = cand_ff;
      cnt_in        = cnt_ff;
      zero_in       = zero_ff;
      sqrt_ctl      = '0;
      div_ctl       = '0;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_large_in  = rsp_large_ff;
      rsp_small_in  = rsp_small_ff;
      rsp_nosol_in  = rsp_nosol_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               num_in        = masked;
               sqrt_ctl.load = 1'b1;
               cnt_in        = CNT_W'(ROOT_W - 1);
               zero_in       = (masked == '0);
               cand_in       = '0;
               state_in      = (masked == '0) ? ST_EMIT : ST_ROOT;
            end
         end
         ST_ROOT: begin
            sqrt_ctl.step = 1'b1;
            cnt_in        = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (cand_ff == '0) begin
               cand_in = root;
            end
            div_ctl.load = 1'b1;
            cnt_in       = CNT_W'(EFF_W - 1);
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            div_ctl.step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (rem_zero) begin
               state_in = ST_EMIT;
            end else begin
               cand_in  = cand_ff - 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_large_in = zero_ff ? '0 : NSFP_PORT_W'(quotient);
               rsp_small_in = NSFP_SMALL_W'(cand_ff);
               rsp_nosol_in = zero_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff       <= num_in;
      cand_ff      <= cand_in;
      cnt_ff       <= cnt_in;
      zero_ff      <= zero_in;
      rsp_large_ff <= rsp_large_in;
      rsp_small_ff <= rsp_small_in;
      rsp_nosol_ff <= rsp_nosol_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_larger_factor  = rsp_large_ff;
   assign rsp_smaller_factor = rsp_small_ff;
   assign rsp_no_solution    = rsp_nosol_ff;

endmodule

[sim/tb_nearest_square_factor_pair.sv]
// ----------------------------------------------------------------------------
// Nearest-square factor pair testbench
// Sends numbers to the block and checks each returned factor pair against
// pairs computed here from the exact divisor search. Directed numbers come
// first, then random numbers built mostly as products of two nearby factors
// so that the hardware search stays short. The sender runs in bursts and
// pauses a few times until all results are in, and the receiver stalls on a
// rotating pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_nearest_square_factor_pair
   import nsfp_pkg::*;
();

   localparam int CYCLE_LIMIT = 6_000_000;
   localparam int RANDOM_REQUESTS = 100;

   typedef struct packed {
      logic [NSFP_PORT_W-1:0]  larger;
      logic [NSFP_SMALL_W-1:0] smaller;
      logic                    none;
   } factor_pair_type;

   typedef struct {
      logic [NSFP_PORT_W-1:0] number;
      bit                     drain_first;
   } request_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [NSFP_PORT_W-1:0]  req_number = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [NSFP_PORT_W-1:0]  rsp_larger_factor;
   logic [NSFP_SMALL_W-1:0] rsp_smaller_factor;
   logic                    rsp_no_solution;

   request_type     pending_requests[$];
   factor_pair_type expected_pairs[$];
   logic            req_taken = 1'b0;
   int              burst_left = 1;
   int              gap_left = 0;
   int              stall_phase = 0;
   logic [15:0]     stall_pattern = '1;
   int              cycle_count = 0;
   int              error_count = 0;

   nearest_square_factor_pair i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_number         (req_number),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_larger_factor  (rsp_larger_factor),
      .rsp_smaller_factor (rsp_smaller_factor),
      .rsp_no_solution    (rsp_no_solution)
   );

   function automatic factor_pair_type closest_factor_pair(logic [NSFP_PORT_W-1:0] value);
      longint unsigned n;
      longint unsigned root;
      factor_pair_type pair;
      n = value;
      if (NSFP_NUMBER_WIDTH < NSFP_PORT_W) begin
         n = n & ((64'd1 << NSFP_NUMBER_WIDTH) - 1);
      end
      if (n == 0) begin
         pair.larger  = '0;
         pair.smaller = '0;
         pair.none    = 1'b1;
         return pair;
      end
      root = longint'($sqrt(real'(n)));
      while (root * root > n) root--;
      while ((root + 1) * (root + 1) <= n) root++;
      while (root > 1 && (n % root) != 0) root--;
      pair.larger  = NSFP_PORT_W'(n / root);
      pair.smaller = NSFP_SMALL_W'(root);
      pair.none    = 1'b0;
      return pair;
   endfunction

   // Products of two nearby factors keep the downward divisor search short.
   function automatic logic [NSFP_PORT_W-1:0] random_number();
      longint unsigned lower;
      longint unsigned spread;
      case ($urandom_range(0, 19))
         0: return '0;
         1, 2, 3, 4, 5: return NSFP_PORT_W'($urandom_range(1, 4095));
         6, 7, 8: spread = $urandom_range(0, 1024);
         default: spread = $urandom_range(0, 16);
      endcase
      lower = $urandom_range(1, 65535);
      if (lower + spread > 65535) lower = 65535 - spread;
      return NSFP_PORT_W'(lower * (lower + spread));
   endfunction

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin : drive_request
      logic                   next_valid;
      logic [NSFP_PORT_W-1:0] next_number;
      request_type            head;
      next_valid  = req_valid;
      next_number = req_number;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_taken) begin
         next_valid = 1'b0;
         if (gap_left != 0) begin
            gap_left--;
         end else if (pending_requests.size() != 0 &&
                      !(pending_requests[0].drain_first && expected_pairs.size() != 0)) begin
            head        = pending_requests.pop_front();
            next_valid  = 1'b1;
            next_number = head.number;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
               burst_left--;
            end
         end
      end
      req_valid  <= next_valid;
      req_number <= next_number;
   end

   always @(negedge clock) begin
      if (stall_phase == 0) begin
         stall_phase   = $urandom_range(8, 64);
         stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      end else begin
         stall_phase--;
      end
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      rsp_ready <= stall_pattern[0];
   end

   always @(posedge clock) begin : check_response
      factor_pair_type want;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         expected_pairs.push_back(closest_factor_pair(req_number));
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pairs.size() == 0) begin
            $error("Unexpected result: larger_factor %0d smaller_factor %0d no_solution %0d",
                   rsp_larger_factor, rsp_smaller_factor, rsp_no_solution);
            error_count++;
         end else begin
            want = expected_pairs.pop_front();
            if (rsp_larger_factor !== want.larger) begin
               $error("larger_factor: expected %0d, actual %0d", want.larger,
                      rsp_larger_factor);
               error_count++;
            end
            if (rsp_smaller_factor !== want.smaller) begin
               $error("smaller_factor: expected %0d, actual %0d", want.smaller,
                      rsp_smaller_factor);
               error_count++;
            end
            if (rsp_no_solution !== want.none) begin
               $error("no_solution: expected %0d, actual %0d", want.none, rsp_no_solution);
               error_count++;
            end
         end
      end
   end

   initial begin : run_test
      logic [NSFP_PORT_W-1:0] directed[$];
      request_type            item;
      // Zero, one, small primes, the largest 16-bit prime, perfect squares,
      // composites and the extremes of the 32-bit range.
      directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd12, 32'd36,
                   32'd65521, 32'd1000000, 32'h0000FFFF, 32'h40000000,
                   32'hFFFE0001, 32'hFFFF0000, 32'hFFFFFFFF, 32'd0, 32'd7};
      foreach (directed[k]) begin
         item.number      = directed[k];
         item.drain_first = 1'b0;
         pending_requests.push_back(item);
      end
      for (int k = 0; k < RANDOM_REQUESTS; k++) begin
         item.number      = random_number();
         item.drain_first = (k % 30 == 0);
         pending_requests.push_back(item);
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      while (pending_requests.size() != 0 || req_valid || expected_pairs.size() != 0) begin
         @(posedge clock);
      end
      repeat (200) @(posedge clock);
      if (expected_pairs.size() != 0) begin
         $error("%0d results never arrived", expected_pairs.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[nearest_square_factor_pair.f]
sv/nsfp_pkg.sv
sv/nsfp_sqrt.sv
sv/nsfp_div.sv
sv/nearest_square_factor_pair.sv
sim/tb_nearest_square_factor_pair.sv
